// ----- rtl/core/mksm_pkg.sv -----
package mksm_pkg;

    // Default sizing of the matcher.
    localparam int unsigned NUM_PATTERNS_DEF      = 51;
    localparam int unsigned MAX_PATTERN_BYTES_DEF = 24;

    // Keyword table: number of entries and width of each entry in bytes.
    localparam int unsigned TABLE_SIZE  = 51;
    localparam int unsigned TABLE_BYTES = 24;
    localparam int unsigned KW_W        = 8*TABLE_BYTES;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned LANG_W = 32;

    // Keyword lengths in bytes.
    localparam int unsigned KW_LEN [TABLE_SIZE] = '{
        7, 4, 4, 4, 4, 3, 4, 4, 4, 3,
        7, 10, 3, 3, 5, 5, 6, 5, 7, 9,
        9, 6, 5, 6, 6, 6, 6, 7, 7, 12,
        3, 4, 5, 5, 6, 7, 7, 7, 7, 7,
        8, 5, 5, 6, 4, 5, 3, 23, 17, 23,
        17
    };

    // Keyword text, first byte in the most significant occupied byte.
    localparam logic [KW_W-1:0] KW_TEXT [TABLE_SIZE] = '{
        KW_W'(56'h687474703a2f2f),
        KW_W'(32'h2e636f6d),
        KW_W'(32'h2e777777),
        KW_W'(32'h2e6e6574),
        KW_W'(32'h2e6f7267),
        KW_W'(24'h2e7275),
        KW_W'(32'h7777772e),
        KW_W'(32'h776f772d),
        KW_W'(32'h2d776f77),
        KW_W'(24'h2e706c),
        KW_W'(56'h776f7767656172),
        KW_W'(80'h77d0be7767d0b5d0b072),
        KW_W'(24'hd0bc73),
        KW_W'(24'h2d6d73),
        KW_W'(40'h656173792d),
        KW_W'(40'h2d65617379),
        KW_W'(48'hd0b5d0b07379),
        KW_W'(40'h656173d183),
        KW_W'(56'h70726f6a656374),
        KW_W'(72'h7072d0be6ad0b56374),
        KW_W'(72'h7072d0be6ad0b56374),
        KW_W'(48'h2d7261737461),
        KW_W'(40'h7261737461),
        KW_W'(48'h72617374612d),
        KW_W'(48'h72d0b0737461),
        KW_W'(48'h67d0b5d0b072),
        KW_W'(48'h64656c757865),
        KW_W'(56'h64656c7578652d),
        KW_W'(56'h2d64656c757865),
        KW_W'(96'hd0b2d0bed0b2d0b3d0b8d180),
        KW_W'(24'h62697a),
        KW_W'(32'h2e62697a),
        KW_W'(40'h2ed180d183),
        KW_W'(40'h2ed180d184),
        KW_W'(48'h2e622f692f7a),
        KW_W'(56'h2ed0b1d0b8d0b7),
        KW_W'(56'h2ed0b1d0b8d0b7),
        KW_W'(56'h2ed0b1d0b8d0b7),
        KW_W'(56'h2ed0b1d0b8d0b7),
        KW_W'(56'h776f77666c6167),
        KW_W'(64'h77d0be77666c6167),
        KW_W'(40'h2d6c696f6e),
        KW_W'(40'h6c696f6e2d),
        KW_W'(48'h2d6c69d0be6e),
        KW_W'(32'h6c696f6e),
        KW_W'(40'h6c69d0be6e),
        KW_W'(24'h777777),
        KW_W'(184'hd09fd180d0b8d0b3d0bbd0b0d188d0b0d18e20d0bdd0b0),
        KW_W'(136'hd097d0b0d185d0bed0b4d0b820d0bdd0b0),
        KW_W'(184'hd09fd180d0b8d0b3d0bbd0b0d188d0b0d18e20d0bdd0b0),
        KW_W'(136'hd097d0b0d185d0bed0b4d0b820d0bdd0b0)
    };

    // Length of keyword p; entries past the table have no length.
    function automatic int unsigned kw_len(input int unsigned p);
        int unsigned len;
        len = 0;
        if (p < TABLE_SIZE)
        begin
            len = KW_LEN[p];
        end
        return len;
    endfunction

    // Byte j (counted from the start) of keyword p, zero outside the keyword.
    function automatic logic [DATA_W-1:0] kw_byte(input int unsigned p, input int unsigned j);
        logic [DATA_W-1:0] b;
        int unsigned       len;
        b   = '0;
        len = kw_len(p);
        if (j < len)
        begin
            b = KW_TEXT[p][(len-1-j)*DATA_W +: DATA_W];
        end
        return b;
    endfunction

    // ASCII-only lowering: A-Z become a-z, every other byte passes.
    function automatic logic [DATA_W-1:0] ascii_lower(input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/mksm_cell.sv -----
// One keyword position across all keywords. Bit p is set when the first
// CELL_IDX+1 bytes of keyword p end at the newest byte of the message.
module mksm_cell #(
    parameter int unsigned CELL_IDX     = 0,
    parameter int unsigned NUM_PATTERNS = mksm_pkg::NUM_PATTERNS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                shift_en,
    input  logic                                clear,
    input  logic [mksm_pkg::DATA_W-1:0]         byte_in,
    input  logic [NUM_PATTERNS-1:0]             prev_match,
    output logic [NUM_PATTERNS-1:0]             match_next,
    output logic [NUM_PATTERNS-1:0]             match_q
);

    logic [NUM_PATTERNS-1:0] match_reg;

    for (genvar p = 0; p < NUM_PATTERNS; p++)
    begin : g_pat
        if (CELL_IDX < mksm_pkg::kw_len(p))
        begin : g_used
            assign match_next[p] = prev_match[p]
                                 && (byte_in == mksm_pkg::kw_byte(p, CELL_IDX));
        end
        else
        begin : g_unused
            assign match_next[p] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
        end
        else if (shift_en)
        begin
            match_reg <= clear ? '0 : match_next;
        end
    end

    assign match_q = match_reg;

endmodule

// ----- rtl/core/multi_keyword_stream_matcher.sv -----
// A result appears on the master side in the cycle after the last byte of a
// message is accepted. Throughput: one byte per cycle while s_tready is high,
// set by the row of keyword position cells that all advance together on every
// accepted byte. Reset (rst_n, asynchronous, active low) clears every cell, the
// hit flag and the output register, and sets the bypass language code to all ones.
module multi_keyword_stream_matcher #(
    parameter int unsigned NUM_PATTERNS      = mksm_pkg::NUM_PATTERNS_DEF,
    parameter int unsigned MAX_PATTERN_BYTES = mksm_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Slave side: one message byte per transfer.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [7:0] message_byte
    input  logic                              s_tlast,  // last_of_message
    input  logic [32:0]                       s_tuser,  // [0] sender_is_privileged,
                                                        // [32:1] language_id
    // Master side: one verdict per message.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,  // [0] blocked, [7:1] zero
    // Configuration: bypass language code.
    input  logic                              cfg_we,
    input  logic [mksm_pkg::LANG_W-1:0]       cfg_wdata
);

    logic                              in_xfer;
    logic [mksm_pkg::DATA_W-1:0]       low_byte;
    logic                              sender_priv;
    logic [mksm_pkg::LANG_W-1:0]       lang_id;

    logic [mksm_pkg::LANG_W-1:0]       addon_code_reg;
    logic                              hit_seen_reg;
    logic                              hit_seen_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              blocked_reg;
    logic                              blocked_next;

    logic [NUM_PATTERNS-1:0]           cell_q    [MAX_PATTERN_BYTES];
    logic [NUM_PATTERNS-1:0]           cell_next [MAX_PATTERN_BYTES];
    logic [NUM_PATTERNS-1:0]           pat_hit;
    logic                              any_hit;

    // The output register parts the two sides: a new byte is taken whenever
    // the pending verdict is empty or is leaving in this cycle.
    assign s_tready    = !out_valid_reg || m_tready;
    assign in_xfer     = s_tvalid && s_tready;
    assign low_byte    = mksm_pkg::ascii_lower(s_tdata);
    assign sender_priv = s_tuser[0];
    assign lang_id     = s_tuser[32:1];

    // Row of cells. Cell k tracks, for every keyword, whether its first k+1
    // bytes end at the newest byte. Each cell extends the partial matches of
    // its left neighbor by the incoming byte, so a keyword of length L is
    // found when cell L-1 would be set. Cells clear after the last byte, so
    // no match reaches back into an earlier message.
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++)
    begin : g_cell
        logic [NUM_PATTERNS-1:0] prev;

        if (k == 0)
        begin : g_head
            assign prev = '1;
        end
        else
        begin : g_body
            assign prev = cell_q[k-1];
        end

        mksm_cell #(
            .CELL_IDX     (k),
            .NUM_PATTERNS (NUM_PATTERNS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (in_xfer),
            .clear      (s_tlast),
            .byte_in    (low_byte),
            .prev_match (prev),
            .match_next (cell_next[k]),
            .match_q    (cell_q[k])
        );
    end

    // A keyword ends at the current byte when its final position cell fires.
    // Keywords longer than the row can never be seen.
    for (genvar p = 0; p < NUM_PATTERNS; p++)
    begin : g_hit
        if (mksm_pkg::kw_len(p) >= 1 && mksm_pkg::kw_len(p) <= MAX_PATTERN_BYTES)
        begin : g_fits
            assign pat_hit[p] = cell_next[mksm_pkg::kw_len(p) - 1][p];
        end
        else
        begin : g_never
            assign pat_hit[p] = 1'b0;
        end
    end

    assign any_hit = |pat_hit;

    // The hit flag is sticky within a message; the verdict is formed on the
    // last byte, where the bypass inputs are sampled.
    always_comb
    begin
        hit_seen_next  = hit_seen_reg;
        out_valid_next = out_valid_reg;
        blocked_next   = blocked_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_xfer)
        begin
            if (s_tlast)
            begin
                hit_seen_next  = 1'b0;
                out_valid_next = 1'b1;
                blocked_next   = (hit_seen_reg || any_hit)
                               && !sender_priv
                               && (lang_id != addon_code_reg);
            end
            else
            begin
                hit_seen_next = hit_seen_reg || any_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addon_code_reg <= '1;
            hit_seen_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            blocked_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                addon_code_reg <= cfg_wdata;
            end
            hit_seen_reg  <= hit_seen_next;
            out_valid_reg <= out_valid_next;
            blocked_reg   <= blocked_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, blocked_reg};

endmodule
